// ===== hw/rtl/chd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package chd_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int TABLE_AW    = 8;
    localparam int CODE_BITS   = 16;
    localparam int PEND_CAP    = CODE_BITS + 7;
    localparam int MAX_RESULTS = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic       OP_LOAD = 1'b0;
    localparam logic       OP_BYTE = 1'b1;
    localparam logic       CFG_MAX_LEN = 1'b0;
    localparam logic       CFG_COUNT   = 1'b1;
    localparam logic       STAT_OK  = 1'b0;
    localparam logic       STAT_ERR = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [7:0]  entry_index;
        logic [7:0]  entry_symbol;
        logic [4:0]  entry_length;
        logic [15:0] entry_code;
        logic [7:0]  data_byte;
    } chd_in_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic       status;
        logic       last;
    } chd_out_t;

    typedef struct packed {
        logic [7:0]  sym;
        logic [4:0]  len;
        logic [15:0] code;
    } chd_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SEARCH,
        ST_DECIDE,
        ST_FLUSH
    } chd_state_t;

    function automatic logic [15:0] mask16(input logic [4:0] n);
        logic [16:0] t;
        t = (17'd1 << n) - 17'd1;
        return t[15:0];
    endfunction

    function automatic logic [22:0] mask23(input logic [4:0] n);
        logic [23:0] t;
        t = (24'd1 << n) - 24'd1;
        return t[22:0];
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/chd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module chd_front import chd_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire chd_in_t s_data,
    output logic         q_valid,
    input  wire logic    q_ready,
    output chd_in_t      q_data
);

    chd_in_t             mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                push, pop;

    assign s_ready = (count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = mem[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // hold the item in the slot until popped
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= s_data;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/chd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module chd_back import chd_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    q_valid,
    output logic         q_ready,
    input  wire chd_in_t q_data,
    input  wire logic [4:0] max_len,
    input  wire logic [8:0] ent_count,
    output logic         m_valid,
    input  wire logic    m_ready,
    output chd_out_t     m_data,
    output chd_state_t   state,
    output logic         hold_valid
);

    chd_entry_t table_mem [TABLE_DEPTH];
    chd_entry_t rd_data_reg;

    chd_state_t  state_reg, state_next;
    logic [22:0] pend_bits_reg, pend_bits_next;
    logic [4:0]  pend_cnt_reg, pend_cnt_next;
    logic [3:0]  n_reg, n_next;
    logic [15:0] window_reg, window_next;
    logic [8:0]  addr_reg, addr_next;
    logic        rd_valid_reg, rd_valid_next;
    logic        found_reg, found_next;
    logic [15:0] best_pc_reg, best_pc_next;
    logic [4:0]  best_len_reg, best_len_next;
    logic [7:0]  best_sym_reg, best_sym_next;
    logic        hold_valid_reg, hold_valid_next;
    logic [7:0]  hold_sym_reg, hold_sym_next;
    logic        hold_stat_reg, hold_stat_next;
    logic        m_valid_reg, m_valid_next;
    chd_out_t    m_data_reg, m_data_next;

    logic        out_free, take, do_load;
    logic [4:0]  m_eff;
    logic [8:0]  cnt_eff;
    logic [5:0]  sum_cnt;
    logic [15:0] pc, win;
    logic [31:0] wide;
    logic        hit;
    logic [4:0]  left;

    assign m_eff   = (max_len == 5'd0) ? 5'd1 :
                     (max_len > 5'(CODE_BITS)) ? 5'(CODE_BITS) : max_len;
    assign cnt_eff = (ent_count > 9'(TABLE_DEPTH)) ? 9'(TABLE_DEPTH) : ent_count;
    assign out_free = !m_valid_reg || m_ready;
    assign take     = (state_reg == ST_IDLE) && q_valid;
    assign do_load  = take && (q_data.operation == OP_LOAD);
    assign q_ready  = (state_reg == ST_IDLE);
    assign sum_cnt  = 6'(pend_cnt_reg) + 6'd8;
    assign left     = pend_cnt_reg - best_len_reg;

    // window: pending bits left-aligned to the code width, zero filled
    always_comb begin
        if (pend_cnt_reg >= m_eff) begin
            wide = 32'(pend_bits_reg) >> (pend_cnt_reg - m_eff);
        end else begin
            wide = 32'(pend_bits_reg) << (m_eff - pend_cnt_reg);
        end
        win = wide[15:0] & mask16(m_eff);
    end

    // padded code of the entry read last cycle
    always_comb begin
        pc  = ((rd_data_reg.code & mask16(rd_data_reg.len)) << (m_eff - rd_data_reg.len))
              | mask16(m_eff - rd_data_reg.len);
        hit = rd_valid_reg && (rd_data_reg.len != 5'd0) && (rd_data_reg.len <= m_eff)
              && (pc >= window_reg) && (!found_reg || (pc < best_pc_reg));
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (take && q_data.operation == OP_BYTE) begin
                    state_next = (sum_cnt > 6'(PEND_CAP)) ? ST_FLUSH : ST_START;
                end
            end
            ST_START: begin
                state_next = (pend_cnt_reg == 5'd0 || n_reg == 4'(MAX_RESULTS))
                             ? ST_FLUSH : ST_SEARCH;
            end
            ST_SEARCH: begin
                if (addr_reg >= cnt_eff && !rd_valid_reg) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!found_reg || best_len_reg > pend_cnt_reg) begin
                    state_next = !found_reg && hold_valid_reg && !out_free
                                 ? ST_DECIDE : ST_FLUSH;
                end else if (!hold_valid_reg || out_free) begin
                    state_next = ST_START;
                end
            end
            ST_FLUSH: begin
                if (!hold_valid_reg || out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        pend_bits_next  = pend_bits_reg;
        pend_cnt_next   = pend_cnt_reg;
        n_next          = n_reg;
        window_next     = window_reg;
        addr_next       = addr_reg;
        rd_valid_next   = 1'b0;
        found_next      = found_reg;
        best_pc_next    = best_pc_reg;
        best_len_next   = best_len_reg;
        best_sym_next   = best_sym_reg;
        hold_valid_next = hold_valid_reg;
        hold_sym_next   = hold_sym_reg;
        hold_stat_next  = hold_stat_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (take && q_data.operation == OP_BYTE) begin
                    n_next = '0;
                    if (sum_cnt > 6'(PEND_CAP)) begin
                        pend_bits_next  = '0;
                        pend_cnt_next   = '0;
                        hold_valid_next = 1'b1;
                        hold_sym_next   = '0;
                        hold_stat_next  = STAT_ERR;
                    end else begin
                        pend_bits_next = {pend_bits_reg[14:0], q_data.data_byte};
                        pend_cnt_next  = sum_cnt[4:0];
                    end
                end
            end
            ST_START: begin
                window_next = win;
                addr_next   = '0;
                found_next  = 1'b0;
            end
            ST_SEARCH: begin
                if (addr_reg < cnt_eff) begin
                    addr_next     = addr_reg + 9'd1;
                    rd_valid_next = 1'b1;
                end
                if (hit) begin
                    found_next    = 1'b1;
                    best_pc_next  = pc;
                    best_len_next = rd_data_reg.len;
                    best_sym_next = rd_data_reg.sym;
                end
            end
            ST_DECIDE: begin
                if (found_reg && best_len_reg > pend_cnt_reg) begin
                    // too few bits: keep them for the next byte
                end else if (!hold_valid_reg || out_free) begin
                    if (hold_valid_reg) begin
                        m_valid_next = 1'b1;
                        m_data_next  = '{symbol: hold_sym_reg, status: hold_stat_reg,
                                         last: 1'b0};
                    end
                    hold_valid_next = 1'b1;
                    n_next          = n_reg + 4'd1;
                    if (!found_reg) begin
                        hold_sym_next  = '0;
                        hold_stat_next = STAT_ERR;
                        pend_bits_next = '0;
                        pend_cnt_next  = '0;
                    end else begin
                        hold_sym_next  = best_sym_reg;
                        hold_stat_next = STAT_OK;
                        pend_cnt_next  = left;
                        pend_bits_next = pend_bits_reg & mask23(left);
                    end
                end
            end
            ST_FLUSH: begin
                if (hold_valid_reg && out_free) begin
                    m_valid_next    = 1'b1;
                    m_data_next     = '{symbol: hold_sym_reg, status: hold_stat_reg,
                                        last: 1'b1};
                    hold_valid_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_bits_reg  <= '0;
            pend_cnt_reg   <= '0;
            n_reg          <= '0;
            rd_valid_reg   <= 1'b0;
            found_reg      <= 1'b0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            addr_reg       <= '0;
        end else begin
            state_reg      <= state_next;
            pend_bits_reg  <= pend_bits_next;
            pend_cnt_reg   <= pend_cnt_next;
            n_reg          <= n_next;
            rd_valid_reg   <= rd_valid_next;
            found_reg      <= found_next;
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
            addr_reg       <= addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        window_reg   <= window_next;
        best_pc_reg  <= best_pc_next;
        best_len_reg <= best_len_next;
        best_sym_reg <= best_sym_next;
        hold_sym_reg <= hold_sym_next;
        hold_stat_reg <= hold_stat_next;
        m_data_reg   <= m_data_next;
    end

    // table: one write port for loads, one registered read port for the sweep
    always_ff @(posedge aclk) begin
        if (do_load) begin
            table_mem[q_data.entry_index[TABLE_AW-1:0]] <=
                '{sym: q_data.entry_symbol, len: q_data.entry_length,
                  code: q_data.entry_code};
        end
        rd_data_reg <= table_mem[addr_reg[TABLE_AW-1:0]];
    end

    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;
    assign state      = state_reg;
    assign hold_valid = hold_valid_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/canonical_huffman_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Canonical Huffman decoder.
// Input channel (s_valid/s_ready/s_data) carries items of two kinds: a table
// load (operation 0) writes one code entry, a stream byte (operation 1)
// appends eight bits, MSB first, to the pending buffer and decodes them.
// Result channel (m_valid/m_ready/m_data) gives symbols with a status; last
// marks the final result caused by a byte. Loads give no result.
// cfg_we/cfg_index/cfg_data write max_code_length (index 0) and entry_count
// (index 1); write them only while the block is idle.
// A four-entry queue takes items while the decoder is busy; an item is
// registered in the queue and reaches the decoder once it is at the queue
// head and the decoder is idle. Each decode sweeps the table one entry per
// cycle from the single read port; a byte keeps the decoder busy until its
// last result is in the output register. A load writes the table when popped.
// Results go through an output register; when the receiver stalls, decoding
// holds and the queue fills, then s_ready drops.
// Reset empties the queue and the pending buffer and sets max_code_length to
// 16 and entry_count to 0; the code table keeps its contents and must be
// loaded before use.
module canonical_huffman_decoder import chd_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire chd_in_t    s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output chd_out_t        m_data,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [8:0] cfg_data
);

    logic [4:0] max_len_reg;
    logic [8:0] count_reg;
    logic       q_valid, q_ready;
    chd_in_t    q_data;
    chd_state_t state;
    logic       hold_valid;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= 5'd16;
            count_reg   <= '0;
        end else if (cfg_we) begin
            if (cfg_index == CFG_MAX_LEN) begin
                max_len_reg <= cfg_data[4:0];
            end else begin
                count_reg <= cfg_data;
            end
        end
    end

    chd_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data)
    );

    chd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_data     (q_data),
        .max_len    (max_len_reg),
        .ent_count  (count_reg),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .state      (state),
        .hold_valid (hold_valid)
    );

    // a held result never survives into idle
    a_idle_no_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        state == ST_IDLE |-> !hold_valid)
        else $error("result held while idle");

    // error results carry symbol zero
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == STAT_ERR |-> m_data.symbol == 8'd0)
        else $error("error result with nonzero symbol");

    // queue is popped only from idle
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid && q_ready |-> state == ST_IDLE)
        else $error("queue popped while busy");

endmodule
`default_nettype wire
